### rtl/pcf_pkg.sv
// ----------------------------------------------------------------------------
// pcf_pkg
// Shared types, constants and the Bernstein weight function of the path
// command flattener.
// ----------------------------------------------------------------------------
package pcf_pkg;

    localparam int MAX_PATHS = 10;
    localparam int SEGMENTS  = 10;

    localparam int COORD_W = 32;
    localparam int OP_W    = 3;
    localparam int IDX_W   = 4;

    localparam logic [OP_W-1:0] OP_MOVE  = 3'd0;
    localparam logic [OP_W-1:0] OP_LINE  = 3'd1;
    localparam logic [OP_W-1:0] OP_HORIZ = 3'd2;
    localparam logic [OP_W-1:0] OP_VERT  = 3'd3;
    localparam logic [OP_W-1:0] OP_CUBIC = 3'd4;
    localparam logic [OP_W-1:0] OP_CLOSE = 3'd5;

    // Curve sample k is the weighted sum of four control points over DENOM.
    localparam int DENOM  = SEGMENTS * SEGMENTS * SEGMENTS;
    localparam int DEN_W  = $clog2(DENOM + 1);
    localparam int HALF   = DENOM / 2;
    localparam int K_W    = $clog2(SEGMENTS + 1);
    localparam int PROD_W = COORD_W + DEN_W + 1;
    localparam int ACC_W  = PROD_W + 2;

    localparam int DIV_BITS  = 4;
    localparam int DIV_STEPS = COORD_W / DIV_BITS;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    localparam int MAC_TERMS = 8;
    localparam int MAC_CNT_W = $clog2(MAC_TERMS + 1);

    typedef struct packed {
        logic [OP_W-1:0]           op;
        logic                      has_letter;
        logic signed [COORD_W-1:0] coord_x1;
        logic signed [COORD_W-1:0] coord_y1;
        logic signed [COORD_W-1:0] coord_x2;
        logic signed [COORD_W-1:0] coord_y2;
        logic signed [COORD_W-1:0] coord_x3;
        logic signed [COORD_W-1:0] coord_y3;
    } pcf_in_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic [IDX_W-1:0]          subpath_number;
        logic                      is_hole;
        logic                      last;
    } pcf_out_t;

    typedef struct packed {
        logic                 capture;
        logic                 wt_load;
        logic [K_W-1:0]       wt_k;
        logic                 mac_en;
        logic [MAC_CNT_W-1:0] mac_cnt;
        logic                 div_load;
        logic                 div_step;
        logic                 load_out;
        logic                 last;
        logic                 from_div;
    } pcf_ctl_t;

    typedef struct packed {
        logic start_single;
        logic start_cubic;
        logic out_free;
    } pcf_sts_t;

    // Bernstein weight j of sample k, scaled by SEGMENTS cubed.
    function automatic logic [DEN_W-1:0] bez_weight(input logic [K_W-1:0] k,
                                                    input logic [1:0] j);
        int m;
        int kk;
        int w;
        kk = int'(k);
        m  = SEGMENTS - kk;
        unique case (j)
            2'd0:    w = m * m * m;
            2'd1:    w = 3 * m * m * kk;
            2'd2:    w = 3 * m * kk * kk;
            default: w = kk * kk * kk;
        endcase
        return DEN_W'(w);
    endfunction

endpackage

### rtl/pcf_divider.sv
// ----------------------------------------------------------------------------
// pcf_divider
// Divides a weighted sum by SEGMENTS cubed, rounding to nearest with ties
// away from zero, DIV_BITS quotient bits per step.
// ----------------------------------------------------------------------------
module pcf_divider (
    input  logic                              clk,
    input  logic                              load,
    input  logic                              step,
    input  logic signed [pcf_pkg::ACC_W-1:0]  acc_in,
    output logic signed [pcf_pkg::COORD_W-1:0] quot
);
    import pcf_pkg::*;

    logic               neg_reg;
    logic [DEN_W-1:0]   rem_reg;
    logic [COORD_W-1:0] low_reg;

    logic [ACC_W-1:0]   mag;
    logic [ACC_W-1:0]   biased;
    logic [DEN_W-1:0]   rem_next;
    logic [COORD_W-1:0] low_next;

    // The biased magnitude is below DENOM times 2^32, so its upper part is
    // already a valid partial remainder and only 32 quotient bits remain.
    always_comb
    begin
        logic [DEN_W:0] trial;
        mag      = acc_in[ACC_W-1] ? ACC_W'(-acc_in) : ACC_W'(acc_in);
        biased   = mag + ACC_W'(HALF);
        rem_next = rem_reg;
        low_next = low_reg;
        for (int i = 0; i < DIV_BITS; i++)
        begin
            trial    = {rem_next, low_next[COORD_W-1]};
            low_next = {low_next[COORD_W-2:0], 1'b0};
            if (trial >= (DEN_W+1)'(DENOM))
            begin
                trial       = trial - (DEN_W+1)'(DENOM);
                low_next[0] = 1'b1;
            end
            rem_next = trial[DEN_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            neg_reg <= acc_in[ACC_W-1];
            rem_reg <= biased[COORD_W +: DEN_W];
            low_reg <= biased[COORD_W-1:0];
        end
        else if (step)
        begin
            rem_reg <= rem_next;
            low_reg <= low_next;
        end
    end

    assign quot = neg_reg ? -$signed(low_reg) : $signed(low_reg);

endmodule

### rtl/pcf_datapath.sv
// ----------------------------------------------------------------------------
// pcf_datapath
// Path state, command capture, shared multiply-accumulate, two dividers and
// the output register of the path command flattener.
// ----------------------------------------------------------------------------
module pcf_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  pcf_pkg::pcf_in_t  cmd_data,
    input  pcf_pkg::pcf_ctl_t ctl,
    output pcf_pkg::pcf_sts_t sts,
    output logic              point_valid,
    input  logic              point_ready,
    output pcf_pkg::pcf_out_t point_data
);
    import pcf_pkg::*;

    logic signed [COORD_W-1:0] cur_x_reg, cur_y_reg, begin_x_reg, begin_y_reg;
    logic [IDX_W-1:0]          idx_reg;
    logic                      nonempty_reg;
    logic                      prev_move_reg;
    logic                      out_valid_reg;

    logic signed [COORD_W-1:0] p0x_reg, p0y_reg, p1x_reg, p1y_reg;
    logic signed [COORD_W-1:0] p2x_reg, p2y_reg, p3x_reg, p3y_reg;
    logic signed [COORD_W-1:0] pt_x_reg, pt_y_reg;
    logic [DEN_W-1:0]          w_reg [4];
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [ACC_W-1:0]   acc_x_reg, acc_y_reg;
    pcf_out_t                  out_reg;

    logic                      open_sub;
    logic [IDX_W-1:0]          idx_next;
    logic                      nonempty_mid;
    logic                      single;
    logic signed [COORD_W-1:0] pt_x_next, pt_y_next;
    logic signed [COORD_W-1:0] q_x, q_y;
    logic signed [COORD_W-1:0] coord_sel;
    logic [DEN_W-1:0]          w_sel;
    logic signed [PROD_W-1:0]  prod_next;
    logic [2:0]                acc_sel;

    // A letter move after a non-move letter starts a hole, unless the current
    // subpath is still empty or the last subpath is already in use.
    assign open_sub = (cmd_data.op == OP_MOVE) && cmd_data.has_letter && !prev_move_reg
                      && nonempty_reg && (idx_reg < IDX_W'(MAX_PATHS - 1));
    assign idx_next     = open_sub ? idx_reg + 1'b1 : idx_reg;
    assign nonempty_mid = open_sub ? 1'b0 : nonempty_reg;

    always_comb
    begin
        pt_x_next = cmd_data.coord_x1;
        pt_y_next = cmd_data.coord_y1;
        single    = 1'b0;
        unique case (cmd_data.op)
            OP_MOVE, OP_LINE:
            begin
                single = 1'b1;
            end
            OP_HORIZ:
            begin
                single    = 1'b1;
                pt_y_next = cur_y_reg;
            end
            OP_VERT:
            begin
                single    = 1'b1;
                pt_x_next = cur_x_reg;
            end
            OP_CLOSE:
            begin
                single    = nonempty_mid;
                pt_x_next = begin_x_reg;
                pt_y_next = begin_y_reg;
            end
            default:
            begin
                single = 1'b0;
            end
        endcase
    end

    assign sts.start_single = single;
    assign sts.start_cubic  = (cmd_data.op == OP_CUBIC);
    assign sts.out_free     = !out_valid_reg || point_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            begin_x_reg   <= '0;
            begin_y_reg   <= '0;
            idx_reg       <= '0;
            nonempty_reg  <= 1'b0;
            prev_move_reg <= 1'b1;
        end
        else if (ctl.capture)
        begin
            idx_reg      <= idx_next;
            nonempty_reg <= nonempty_mid || single || sts.start_cubic;
            if (cmd_data.has_letter)
            begin
                prev_move_reg <= (cmd_data.op == OP_MOVE);
            end
            unique case (cmd_data.op)
                OP_MOVE:
                begin
                    cur_x_reg   <= cmd_data.coord_x1;
                    cur_y_reg   <= cmd_data.coord_y1;
                    begin_x_reg <= cmd_data.coord_x1;
                    begin_y_reg <= cmd_data.coord_y1;
                end
                OP_LINE:
                begin
                    cur_x_reg <= cmd_data.coord_x1;
                    cur_y_reg <= cmd_data.coord_y1;
                end
                OP_HORIZ: cur_x_reg <= cmd_data.coord_x1;
                OP_VERT:  cur_y_reg <= cmd_data.coord_y1;
                OP_CUBIC:
                begin
                    cur_x_reg <= cmd_data.coord_x3;
                    cur_y_reg <= cmd_data.coord_y3;
                end
                default:
                begin
                end
            endcase
        end
    end

    // The curve keeps its own copy of the start point, since the current
    // point moves to the end point at capture.
    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            p0x_reg  <= cur_x_reg;
            p0y_reg  <= cur_y_reg;
            p1x_reg  <= cmd_data.coord_x1;
            p1y_reg  <= cmd_data.coord_y1;
            p2x_reg  <= cmd_data.coord_x2;
            p2y_reg  <= cmd_data.coord_y2;
            p3x_reg  <= cmd_data.coord_x3;
            p3y_reg  <= cmd_data.coord_y3;
            pt_x_reg <= pt_x_next;
            pt_y_reg <= pt_y_next;
        end
        if (ctl.wt_load)
        begin
            for (int j = 0; j < 4; j++)
            begin
                w_reg[j] <= bez_weight(ctl.wt_k, 2'(j));
            end
        end
    end

    always_comb
    begin
        unique case (ctl.mac_cnt[2:0])
            3'd0:    coord_sel = p0x_reg;
            3'd1:    coord_sel = p1x_reg;
            3'd2:    coord_sel = p2x_reg;
            3'd3:    coord_sel = p3x_reg;
            3'd4:    coord_sel = p0y_reg;
            3'd5:    coord_sel = p1y_reg;
            3'd6:    coord_sel = p2y_reg;
            default: coord_sel = p3y_reg;
        endcase
    end

    assign w_sel     = w_reg[ctl.mac_cnt[1:0]];
    assign prod_next = PROD_W'(coord_sel) * PROD_W'($signed({1'b0, w_sel}));
    assign acc_sel   = 3'(ctl.mac_cnt - MAC_CNT_W'(1));

    // The product of term c is added in the cycle after it is formed.
    always_ff @(posedge clk)
    begin
        if (ctl.mac_en)
        begin
            if (ctl.mac_cnt < MAC_CNT_W'(MAC_TERMS))
            begin
                prod_reg <= prod_next;
            end
            if (ctl.mac_cnt != '0)
            begin
                if (!acc_sel[2])
                begin
                    acc_x_reg <= (acc_sel[1:0] == 2'd0) ? ACC_W'(prod_reg)
                                                        : acc_x_reg + ACC_W'(prod_reg);
                end
                else
                begin
                    acc_y_reg <= (acc_sel[1:0] == 2'd0) ? ACC_W'(prod_reg)
                                                        : acc_y_reg + ACC_W'(prod_reg);
                end
            end
        end
    end

    pcf_divider u_div_x (
        .clk    (clk),
        .load   (ctl.div_load),
        .step   (ctl.div_step),
        .acc_in (acc_x_reg),
        .quot   (q_x)
    );

    pcf_divider u_div_y (
        .clk    (clk),
        .load   (ctl.div_load),
        .step   (ctl.div_step),
        .acc_in (acc_y_reg),
        .quot   (q_y)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (point_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_out)
        begin
            out_reg.point_x        <= ctl.from_div ? q_x : pt_x_reg;
            out_reg.point_y        <= ctl.from_div ? q_y : pt_y_reg;
            out_reg.subpath_number <= idx_reg;
            out_reg.is_hole        <= (idx_reg != '0);
            out_reg.last           <= ctl.last;
        end
    end

    assign point_valid = out_valid_reg;
    assign point_data  = out_reg;

endmodule

### rtl/pcf_ctrl.sv
// ----------------------------------------------------------------------------
// pcf_ctrl
// Sequencer of the path command flattener: command capture, per-sample
// multiply-accumulate and divide phases, and point hand-off.
// ----------------------------------------------------------------------------
module pcf_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  pcf_pkg::pcf_sts_t sts,
    output pcf_pkg::pcf_ctl_t ctl
);
    import pcf_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MAC  = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    logic [1:0]           state_reg, state_next;
    logic [MAC_CNT_W-1:0] mac_cnt_reg, mac_cnt_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic [K_W-1:0]       k_reg, k_next;
    logic                 cubic_reg, cubic_next;

    assign cmd_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        mac_cnt_next = mac_cnt_reg;
        div_cnt_next = div_cnt_reg;
        k_next       = k_reg;
        cubic_next   = cubic_reg;
        ctl          = '0;
        ctl.mac_cnt  = mac_cnt_reg;
        ctl.wt_k     = k_reg;
        ctl.last     = !cubic_reg || (k_reg == K_W'(SEGMENTS));
        ctl.from_div = cubic_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                ctl.capture = cmd_valid;
                if (cmd_valid)
                begin
                    if (sts.start_cubic)
                    begin
                        state_next   = S_MAC;
                        mac_cnt_next = '0;
                        k_next       = '0;
                        cubic_next   = 1'b1;
                        ctl.wt_load  = 1'b1;
                        ctl.wt_k     = '0;
                    end
                    else if (sts.start_single)
                    begin
                        state_next = S_EMIT;
                        cubic_next = 1'b0;
                    end
                end
            end
            S_MAC:
            begin
                ctl.mac_en = 1'b1;
                if (mac_cnt_reg == MAC_CNT_W'(MAC_TERMS))
                begin
                    state_next   = S_DIV;
                    div_cnt_next = '0;
                end
                else
                begin
                    mac_cnt_next = mac_cnt_reg + 1'b1;
                end
            end
            S_DIV:
            begin
                ctl.div_load = (div_cnt_reg == '0);
                ctl.div_step = (div_cnt_reg != '0);
                if (div_cnt_reg == DIV_CNT_W'(DIV_STEPS))
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    div_cnt_next = div_cnt_reg + 1'b1;
                end
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    ctl.load_out = 1'b1;
                    if (ctl.last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next   = S_MAC;
                        mac_cnt_next = '0;
                        k_next       = k_reg + 1'b1;
                        ctl.wt_load  = 1'b1;
                        ctl.wt_k     = k_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            mac_cnt_reg <= '0;
            div_cnt_reg <= '0;
            k_reg       <= '0;
            cubic_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            mac_cnt_reg <= mac_cnt_next;
            div_cnt_reg <= div_cnt_next;
            k_reg       <= k_next;
            cubic_reg   <= cubic_next;
        end
    end

endmodule

### rtl/path_command_flattener.sv
// ----------------------------------------------------------------------------
// path_command_flattener
// Turns tokenized vector path commands into a stream of Q16.16 points.
// ----------------------------------------------------------------------------
// Usage:
// One command request enters on cmd_valid/cmd_ready with cmd_data; points
// leave on point_valid/point_ready with point_data, the last point of each
// command marked by last. Move, line, horizontal, vertical and a close on a
// nonempty subpath give one point; a cubic gives SEGMENTS+1 samples; other
// commands give none and only update the letter tracking.
// A single-point command is captured while the sequencer is idle and its
// point enters the output register from the hand-off step; no new command is
// taken until then. For each of its eleven samples a cubic runs the shared
// multiply-accumulate (four terms per axis plus a drain step), the two
// radix-16 dividers and the hand-off, and it holds the input until the last
// sample is handed off. A command with no point leaves the sequencer idle.
// cmd_ready is high only while the sequencer is idle; a new command may be
// taken while the final point of the previous one still waits at the output.
// When the receiver stalls, the sequencer holds in its hand-off step until
// the output register frees. Reset clears the current and start points to
// the origin, selects subpath zero as empty and counts the last letter as a
// move.
// ----------------------------------------------------------------------------
module path_command_flattener (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  pcf_pkg::pcf_in_t  cmd_data,
    output logic              point_valid,
    input  logic              point_ready,
    output pcf_pkg::pcf_out_t point_data
);
    import pcf_pkg::*;

    pcf_ctl_t ctl;
    pcf_sts_t sts;

    pcf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .sts       (sts),
        .ctl       (ctl)
    );

    pcf_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_data    (cmd_data),
        .ctl         (ctl),
        .sts         (sts),
        .point_valid (point_valid),
        .point_ready (point_ready),
        .point_data  (point_data)
    );

endmodule

### bench/pcf_point_checker.sv
// ----------------------------------------------------------------------------
// pcf_point_checker
// Watches both channels of the path command flattener, works out the points
// that each accepted command request must produce, and compares every point
// that leaves the block field by field with the oldest one still owed.
// ----------------------------------------------------------------------------
module pcf_point_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    input  logic              cmd_ready,
    input  pcf_pkg::pcf_in_t  cmd_data,
    input  logic              point_valid,
    input  logic              point_ready,
    input  pcf_pkg::pcf_out_t point_data,
    output int                mismatches,
    output int                outstanding,
    output int                points_checked,
    output int                subpath_reached
);

    import pcf_pkg::*;

    logic signed [COORD_W-1:0] pen_x;
    logic signed [COORD_W-1:0] pen_y;
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic [IDX_W-1:0]          subpath;
    logic                      subpath_has_points;
    logic                      last_letter_was_move;

    pcf_out_t pending_points[$];
    pcf_out_t owed;

    // Bernstein sample k of one axis, summed exactly and rounded to nearest
    // with ties away from zero.
    function automatic logic signed [COORD_W-1:0] curve_sample(
        input logic signed [COORD_W-1:0] p0,
        input logic signed [COORD_W-1:0] p1,
        input logic signed [COORD_W-1:0] p2,
        input logic signed [COORD_W-1:0] p3,
        input int                        k
    );
        longint kk;
        longint rem;
        longint den;
        longint num;
        longint q;
        kk  = longint'(k);
        rem = longint'(SEGMENTS - k);
        den = longint'(SEGMENTS) * SEGMENTS * SEGMENTS;
        num = longint'(p0) * (rem * rem * rem)
            + longint'(p1) * (3 * rem * rem * kk)
            + longint'(p2) * (3 * rem * kk * kk)
            + longint'(p3) * (kk * kk * kk);
        if (num >= 0)
            q = (num + den / 2) / den;
        else
            q = -((-num + den / 2) / den);
        return q[COORD_W-1:0];
    endfunction

    function automatic pcf_out_t tag_point(input logic signed [COORD_W-1:0] x,
                                           input logic signed [COORD_W-1:0] y);
        pcf_out_t p;
        p.point_x        = x;
        p.point_y        = y;
        p.subpath_number = subpath;
        p.is_hole        = (subpath != '0);
        p.last           = 1'b0;
        return p;
    endfunction

    task automatic flatten_command(input pcf_in_t c);
        pcf_out_t pts[SEGMENTS+1];
        pcf_out_t p;
        int       n;
        int       k;
        int       i;
        n = 0;
        // A lettered move after some other letter starts a hole, unless the
        // current subpath is still empty or the index is already at its top.
        if (c.op == OP_MOVE && c.has_letter && !last_letter_was_move
            && subpath_has_points && subpath < IDX_W'(MAX_PATHS - 1))
        begin
            subpath++;
            subpath_has_points = 1'b0;
        end
        if (c.has_letter)
            last_letter_was_move = (c.op == OP_MOVE);

        case (c.op)
            OP_MOVE:
            begin
                pts[0]  = tag_point(c.coord_x1, c.coord_y1);
                n       = 1;
                pen_x   = c.coord_x1;
                pen_y   = c.coord_y1;
                start_x = c.coord_x1;
                start_y = c.coord_y1;
            end
            OP_LINE:
            begin
                pts[0] = tag_point(c.coord_x1, c.coord_y1);
                n      = 1;
                pen_x  = c.coord_x1;
                pen_y  = c.coord_y1;
            end
            OP_HORIZ:
            begin
                pts[0] = tag_point(c.coord_x1, pen_y);
                n      = 1;
                pen_x  = c.coord_x1;
            end
            OP_VERT:
            begin
                pts[0] = tag_point(pen_x, c.coord_y1);
                n      = 1;
                pen_y  = c.coord_y1;
            end
            OP_CUBIC:
            begin
                for (k = 0; k <= SEGMENTS; k++)
                    pts[k] = tag_point(
                        curve_sample(pen_x, c.coord_x1, c.coord_x2, c.coord_x3, k),
                        curve_sample(pen_y, c.coord_y1, c.coord_y2, c.coord_y3, k));
                n     = SEGMENTS + 1;
                pen_x = c.coord_x3;
                pen_y = c.coord_y3;
            end
            OP_CLOSE:
            begin
                if (subpath_has_points)
                begin
                    pts[0] = tag_point(start_x, start_y);
                    n      = 1;
                end
            end
            default:
            begin
            end
        endcase

        if (n > 0)
            subpath_has_points = 1'b1;
        for (i = 0; i < n; i++)
        begin
            p      = pts[i];
            p.last = (i == n - 1);
            pending_points.push_back(p);
        end
    endtask

    task automatic check_field(input string name, input logic [COORD_W-1:0] want,
                               input logic [COORD_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pen_x                = '0;
            pen_y                = '0;
            start_x              = '0;
            start_y              = '0;
            subpath              = '0;
            subpath_has_points   = 1'b0;
            last_letter_was_move = 1'b1;
            pending_points.delete();
            mismatches           = 0;
            points_checked       = 0;
        end
        else
        begin
            // Points leaving now belong to earlier requests, so check them
            // before adding what a request taken at this edge will produce.
            if (point_valid && point_ready)
            begin
                if (pending_points.size() == 0)
                begin
                    $error("point (%0h, %0h) arrived with none expected",
                           point_data.point_x, point_data.point_y);
                    mismatches++;
                end
                else
                begin
                    owed = pending_points.pop_front();
                    check_field("point_x", owed.point_x, point_data.point_x);
                    check_field("point_y", owed.point_y, point_data.point_y);
                    check_field("subpath_number", COORD_W'(owed.subpath_number),
                                COORD_W'(point_data.subpath_number));
                    check_field("is_hole", COORD_W'(owed.is_hole),
                                COORD_W'(point_data.is_hole));
                    check_field("last", COORD_W'(owed.last), COORD_W'(point_data.last));
                    points_checked++;
                end
            end
            if (cmd_valid && cmd_ready)
                flatten_command(cmd_data);
        end
        outstanding     = pending_points.size();
        subpath_reached = int'(subpath);
    end

endmodule

### bench/path_command_flattener_tb.sv
// ----------------------------------------------------------------------------
// path_command_flattener_tb
// Drives the path command flattener with a directed opening and then random
// subpaths under several idle and stall patterns, with the checker beside it.
// ----------------------------------------------------------------------------
module path_command_flattener_tb;

    import pcf_pkg::*;

    localparam logic [OP_W-1:0] OP_UNKNOWN = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE   = 3'd7;

    localparam logic signed [COORD_W-1:0] C_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [COORD_W-1:0] C_MIN = 32'sh8000_0000;

    localparam int QUIET_LIMIT   = 5000;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 250;
    localparam int PHASE_ITEMS   = 125;

    logic     clk;
    logic     rst_n;
    logic     cmd_valid;
    logic     cmd_ready;
    pcf_in_t  cmd_data;
    logic     point_valid;
    logic     point_ready;
    pcf_out_t point_data;

    int mismatches;
    int outstanding;
    int points_checked;
    int subpath_reached;

    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int hold_requests      = 0;
    int hold_served;
    int hold_left;
    int commands_sent      = 0;
    int cubics_sent        = 0;
    int drawing_cmds       = 0;
    int quiet;

    path_command_flattener dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .cmd_data    (cmd_data),
        .point_valid (point_valid),
        .point_ready (point_ready),
        .point_data  (point_data)
    );

    pcf_point_checker point_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd_valid       (cmd_valid),
        .cmd_ready       (cmd_ready),
        .cmd_data        (cmd_data),
        .point_valid     (point_valid),
        .point_ready     (point_ready),
        .point_data      (point_data),
        .mismatches      (mismatches),
        .outstanding     (outstanding),
        .points_checked  (points_checked),
        .subpath_reached (subpath_reached)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Receiver side; a long hold-off is asked for by bumping hold_requests.
    initial
    begin
        point_ready = 1'b0;
        hold_served = 0;
        hold_left   = 0;
        forever
        begin
            @(posedge clk);
            if (hold_served != hold_requests)
            begin
                hold_served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                point_ready <= 1'b0;
            end
            else
                point_ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    initial
    begin
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (cmd_valid && cmd_ready) || (point_valid && point_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("path_command_flattener: mismatch");
        $finish;
    end

    function automatic pcf_in_t cmd_of(input logic [OP_W-1:0] op, input logic letter,
                                       input logic signed [COORD_W-1:0] x1,
                                       input logic signed [COORD_W-1:0] y1,
                                       input logic signed [COORD_W-1:0] x2,
                                       input logic signed [COORD_W-1:0] y2,
                                       input logic signed [COORD_W-1:0] x3,
                                       input logic signed [COORD_W-1:0] y3);
        pcf_in_t c;
        c.op         = op;
        c.has_letter = letter;
        c.coord_x1   = x1;
        c.coord_y1   = y1;
        c.coord_x2   = x2;
        c.coord_y2   = y2;
        c.coord_x3   = x3;
        c.coord_y3   = y3;
        return c;
    endfunction

    function automatic logic signed [COORD_W-1:0] rand_coord();
        case ($urandom_range(9))
            0, 1, 2, 3: return $urandom;
            4, 5, 6:    return $urandom_range(2097152) - 1048576;
            7:          return C_MAX;
            8:          return C_MIN;
            default:    return $urandom_range(2) - 1;
        endcase
    endfunction

    task automatic send_cmd(input pcf_in_t c);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_data  <= c;
        do @(negedge clk); while (!cmd_ready);
        @(posedge clk);
        commands_sent++;
        if (c.op == OP_CUBIC)
            cubics_sent++;
        if (c.op <= OP_CLOSE)
            drawing_cmds++;
    endtask

    task automatic send_noise();
        int n;
        int i;
        n = $urandom_range(1, 3);
        for (i = 0; i < n; i++)
            send_cmd(cmd_of(OP_W'($urandom_range(7)), 1'($urandom_range(1)),
                            rand_coord(), rand_coord(), rand_coord(),
                            rand_coord(), rand_coord(), rand_coord()));
    endtask

    // One well-formed subpath: a move, a few drawing commands, often a close.
    task automatic draw_subpath();
        int              draws;
        int              i;
        int              pick;
        logic [OP_W-1:0] op;
        send_cmd(cmd_of(OP_MOVE, $urandom_range(9) != 0, rand_coord(), rand_coord(),
                        rand_coord(), rand_coord(), rand_coord(), rand_coord()));
        draws = $urandom_range(1, 6);
        for (i = 0; i < draws; i++)
        begin
            pick = $urandom_range(9);
            if (pick < 3)
                op = OP_LINE;
            else if (pick < 5)
                op = OP_HORIZ;
            else if (pick < 7)
                op = OP_VERT;
            else if (pick < 9)
                op = OP_CUBIC;
            else
                op = OP_MOVE;
            // Moves in the middle are implicit repeats and never open a hole.
            send_cmd(cmd_of(op, op != OP_MOVE && $urandom_range(3) != 0,
                            rand_coord(), rand_coord(), rand_coord(),
                            rand_coord(), rand_coord(), rand_coord()));
        end
        if ($urandom_range(9) < 7)
            send_cmd(cmd_of(OP_CLOSE, $urandom_range(7) != 0, rand_coord(), rand_coord(),
                            rand_coord(), rand_coord(), rand_coord(), rand_coord()));
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct);
        int target;
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        target             = drawing_cmds + PHASE_ITEMS;
        while (drawing_cmds < target)
        begin
            if ($urandom_range(9) == 0)
                send_noise();
            else
                draw_subpath();
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        cmd_valid = 1'b0;
        cmd_data  = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Close on the empty subpath after reset gives nothing.
        send_cmd(cmd_of(OP_CLOSE, 1'b1, 0, 0, 0, 0, 0, 0));
        send_cmd(cmd_of(OP_UNKNOWN, 1'b1, C_MAX, C_MIN, 1, 2, 3, 4));
        send_cmd(cmd_of(OP_SPARE, 1'b0, C_MIN, C_MAX, 5, 6, 7, 8));
        // Lettered move while the subpath is still empty stays in subpath 0.
        send_cmd(cmd_of(OP_MOVE, 1'b1, 0, 0, 0, 0, 0, 0));
        // From the origin the middle sample sits exactly on a half, both signs.
        send_cmd(cmd_of(OP_CUBIC, 1'b1, 0, 0, 0, 0, 4, -4));
        send_cmd(cmd_of(OP_LINE, 1'b1, C_MAX, C_MIN, 0, 0, 0, 0));
        send_cmd(cmd_of(OP_HORIZ, 1'b1, C_MIN, C_MAX, 0, 0, 0, 0));
        send_cmd(cmd_of(OP_VERT, 1'b1, C_MAX, C_MAX, 0, 0, 0, 0));
        send_cmd(cmd_of(OP_LINE, 1'b0, -1, 1, 0, 0, 0, 0));
        send_cmd(cmd_of(OP_CUBIC, 1'b1, C_MAX, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX));
        send_cmd(cmd_of(OP_CUBIC, 1'b1, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN));
        send_cmd(cmd_of(OP_CLOSE, 1'b1, 0, 0, 0, 0, 0, 0));
        send_cmd(cmd_of(OP_MOVE, 1'b0, 32'sh1234_5678, -32'sh0765_4321, 0, 0, 0, 0));
        send_cmd(cmd_of(OP_MOVE, 1'b1, 32'sh0001_0000, 32'sh0002_0000, 0, 0, 0, 0));
        send_cmd(cmd_of(OP_MOVE, 1'b1, 32'sh0003_0000, 32'sh0004_0000, 0, 0, 0, 0));
        send_cmd(cmd_of(OP_LINE, 1'b1, -32'sh0001_8000, 32'sh0000_8000, 0, 0, 0, 0));
        send_cmd(cmd_of(OP_UNKNOWN, 1'b1, 0, 0, 0, 0, 0, 0));
        // An unknown letter also counts as a non-move before the next move.
        send_cmd(cmd_of(OP_MOVE, 1'b1, -32'sh0005_0000, 32'sh0006_0000, 0, 0, 0, 0));
        send_cmd(cmd_of(OP_CUBIC, 1'b0, 32'sh0010_0000, -32'sh0010_0000,
                        -32'sh0020_0003, 32'sh0030_0007, 32'sh0000_0001, -32'sh0000_0001));
        send_cmd(cmd_of(OP_CLOSE, 1'b1, 0, 0, 0, 0, 0, 0));
        send_cmd(cmd_of(OP_CLOSE, 1'b1, 0, 0, 0, 0, 0, 0));

        run_phase(0, 0);
        hold_requests++;
        run_phase(0, 61);
        run_phase(61, 0);
        run_phase(32, 32);
        cmd_valid <= 1'b0;

        while (outstanding != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Ran %0d command requests (%0d cubic curves) and checked %0d points,",
                 commands_sent, cubics_sent, points_checked);
        $display("reaching subpath %0d across idle, stall and long hold-off phases.",
                 subpath_reached);
        if (mismatches == 0 && outstanding == 0)
            $display("path_command_flattener: match");
        else
            $display("path_command_flattener: mismatch");
        $finish;
    end

endmodule
